// ===== design/geb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gershgorin bounds package
// Field widths, data types and the sweep control bundle shared by the block.
// ----------------------------------------------------------------------------
package geb_pkg;

   localparam int IDX_W      = 8;
   localparam int CFG_W      = 9;
   localparam int CSR_DATA_W = 16;
   localparam int CENTRE_W   = 32;
   localparam int MAG_W      = 32;
   localparam int RADIUS_W   = 47;
   localparam int BOUND_W    = 48;
   localparam int REQ_DATA_W = 2 * IDX_W + CENTRE_W;
   localparam int RSP_DATA_W = 2 * BOUND_W;

   localparam logic [RADIUS_W-1:0] RADIUS_MAX = {RADIUS_W{1'b1}};

   typedef logic signed [CENTRE_W-1:0] centre_type;
   typedef logic [RADIUS_W-1:0]        radius_type;
   typedef logic signed [BOUND_W-1:0]  bound_type;

   // one row of centre/radius read data is on the data stage
   typedef struct packed {
      logic valid;
      logic first;
   } sweep_type;

endpackage

// ===== design/geb_interval.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gershgorin interval accumulator
// Forms centre-radius and centre+radius per row, saturates them to 48 bits
// and keeps the running minimum and maximum over one sweep.
// ----------------------------------------------------------------------------
module geb_interval (
   input  logic                clock,
   input  logic                reset,
   input  geb_pkg::sweep_type  sweep,
   input  geb_pkg::centre_type centre,
   input  geb_pkg::radius_type radius,
   output geb_pkg::bound_type  lower_bound,
   output geb_pkg::bound_type  upper_bound
);
   import geb_pkg::*;

   localparam int SUM_W = BOUND_W + 1;
   localparam logic [BOUND_W-1:0] BOUND_MIN = {1'b1, {(BOUND_W-1){1'b0}}};
   localparam logic [BOUND_W-1:0] BOUND_MAX = {1'b0, {(BOUND_W-1){1'b1}}};

   logic signed [SUM_W-1:0] centre_ext;
   logic signed [SUM_W-1:0] radius_ext;
   logic signed [SUM_W-1:0] diff;
   logic signed [SUM_W-1:0] total;
   bound_type               lo_sat;
   bound_type               hi_sat;
   bound_type               low_ff;
   bound_type               low_in;
   bound_type               high_ff;
   bound_type               high_in;

   function automatic bound_type sat_bound(input logic signed [SUM_W-1:0] v);
      bound_type r;
      if (v[SUM_W-1] != v[SUM_W-2]) begin
         r = v[SUM_W-1] ? BOUND_MIN : BOUND_MAX;
      end else begin
         r = v[BOUND_W-1:0];
      end
      return r;
   endfunction

   assign centre_ext = {{(SUM_W-CENTRE_W){centre[CENTRE_W-1]}}, centre};
   assign radius_ext = {{(SUM_W-RADIUS_W){1'b0}}, radius};
   assign diff       = centre_ext - radius_ext;
   assign total      = centre_ext + radius_ext;
   assign lo_sat     = sat_bound(diff);
   assign hi_sat     = sat_bound(total);

   always_comb begin
      low_in  = low_ff;
      high_in = high_ff;
      if (sweep.valid) begin
         if (sweep.first || lo_sat < low_ff) begin
            low_in = lo_sat;
         end
         if (sweep.first || hi_sat > high_ff) begin
            high_in = hi_sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff  <= '0;
         high_ff <= '0;
      end else begin
         low_ff  <= low_in;
         high_ff <= high_in;
      end
   end

   assign lower_bound = low_ff;
   assign upper_bound = high_ff;

endmodule

// ===== design/gershgorin_eigen_bounds.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gershgorin eigenvalue bounds
// Collects centres and radii of a symmetric profile matrix in two on-chip
// memories and sweeps them into one eigenvalue interval per matrix.
// ----------------------------------------------------------------------------
//  channel | ports        | transaction carries
//  --------+--------------+------------------------------------------------
//  req     | req_t*       | one stored lower-triangle entry (tlast = final)
//  rsp     | rsp_t*       | lower and upper bound, Q31.16
//  csr     | csr_t*       | matrix order
//
// Off-diagonal entry: read row radius, then write row and read column, then
// write column; diagonal or out-of-range entry: the row step alone. The
// single write port of the radius memory forces the separate column step.
// Final entry: its own steps, then a sweep over rows 0 to N-1 and a load
// into the output register; N is the larger of the order and the highest
// order under which a radius was updated since the last sweep. The sweep
// zeroes each radius it reads, rows past the order included.
// After reset a clearing pass zeroes all MAX_ORDER rows of the radius memory;
// req_tready stays low meanwhile. csr writes are taken in any cycle.
// A result waiting in the output register stalls only the next load.
// ----------------------------------------------------------------------------
module gershgorin_eigen_bounds #(
   parameter int MAX_ORDER = 256
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // row_index [7:0], col_index [15:8], entry_value [47:16]
   input  logic [geb_pkg::REQ_DATA_W-1:0]   req_tdata,
   // last_entry
   input  logic                             req_tlast,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // lower_bound [47:0], upper_bound [95:48]
   output logic [geb_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                             csr_tvalid,
   output logic                             csr_tready,
   // matrix_order [8:0], zeros above
   input  logic [geb_pkg::CSR_DATA_W-1:0]   csr_tdata
);
   import geb_pkg::*;

   localparam int AW  = $clog2(MAX_ORDER);
   localparam int OW  = $clog2(MAX_ORDER + 1);
   localparam int NW  = (OW > CFG_W) ? OW : CFG_W;
   localparam logic [NW-1:0] ORDER_MAX = NW'(MAX_ORDER);
   localparam logic [NW-1:0] LAST_ROW  = NW'(MAX_ORDER - 1);
   localparam logic [NW-1:0] ORDER_ONE = NW'(1);

   typedef enum logic [5:0] {
      ST_CLEAR  = 6'b000001,
      ST_IDLE   = 6'b000010,
      ST_ROW    = 6'b000100,
      ST_COL    = 6'b001000,
      ST_SWEEP  = 6'b010000,
      ST_RESULT = 6'b100000
   } state_type;

   state_type              state_ff, state_in;
   logic [NW-1:0]          order_ff, order_in;
   logic [NW-1:0]          span_ff, span_in;
   logic [IDX_W-1:0]       row_ff, col_ff;
   centre_type             value_ff;
   logic [MAG_W-1:0]       mag_ff;
   logic                   last_ff;
   logic [NW-1:0]          sweep_row_ff, sweep_row_in;
   sweep_type              sw_ff, sw_in;
   logic                   sw_clr_ff, sw_clr_in;
   logic [AW-1:0]          sw_row_ff;
   radius_type             radius_rd_ff;
   centre_type             centre_rd_ff;
   logic                   fwd_hit_ff, fwd_hit_in;
   radius_type             fwd_data_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]  rsp_data_ff;

   radius_type             radius_mem [MAX_ORDER];
   centre_type             centre_mem [MAX_ORDER];

   logic                   req_accept;
   logic                   in_range, is_diag, off_diag_upd, item_done, rsp_load;
   logic [AW-1:0]          rad_raddr, rad_waddr;
   logic                   rad_we;
   radius_type             rad_wdata;
   logic                   cen_we;
   radius_type             radius_cur, radius_new;
   logic [RADIUS_W:0]      radius_sum;
   logic [NW-1:0]          cfg_ext;
   logic [NW-1:0]          sweep_top;
   logic signed [CENTRE_W-1:0] req_value;
   bound_type              lower_bound, upper_bound;

   function automatic logic [AW-1:0] to_addr(input logic [IDX_W-1:0] idx);
      logic [NW-1:0] w;
      w = NW'(idx);
      return w[AW-1:0];
   endfunction

   // ---------------- configuration ----------------
   assign csr_tready = 1'b1;
   assign cfg_ext    = NW'(csr_tdata[CFG_W-1:0]);

   always_comb begin
      order_in = order_ff;
      if (csr_tvalid) begin
         if (cfg_ext == '0) begin
            order_in = ORDER_ONE;
         end else if (cfg_ext > ORDER_MAX) begin
            order_in = ORDER_MAX;
         end else begin
            order_in = cfg_ext;
         end
      end
   end

   // ---------------- item decode ----------------
   assign req_value    = req_tdata[REQ_DATA_W-1:2*IDX_W];
   assign in_range     = (NW'(row_ff) < order_ff) && (NW'(col_ff) < order_ff);
   assign is_diag      = (row_ff == col_ff);
   assign off_diag_upd = in_range && !is_diag;
   assign item_done    = ((state_ff == ST_ROW) && !off_diag_upd) || (state_ff == ST_COL);
   assign req_tready   = (state_ff == ST_IDLE) || (item_done && !last_ff);
   assign req_accept   = req_tvalid && req_tready;

   // column write can land on the row the next item reads in the same cycle
   assign radius_cur = fwd_hit_ff ? fwd_data_ff : radius_rd_ff;
   assign radius_sum = {1'b0, radius_cur} + (RADIUS_W+1)'(mag_ff);
   assign radius_new = radius_sum[RADIUS_W] ? RADIUS_MAX : radius_sum[RADIUS_W-1:0];

   // rows touched under a larger order than the current one still need zeroing
   assign sweep_top = (span_ff > order_ff) ? span_ff : order_ff;

   always_comb begin
      span_in = span_ff;
      if (state_ff == ST_RESULT) begin
         span_in = '0;
      end else if (state_ff == ST_ROW && off_diag_upd && order_ff > span_ff) begin
         span_in = order_ff;
      end
   end

   // ---------------- memory access ----------------
   always_comb begin
      rad_we    = 1'b0;
      rad_waddr = to_addr(row_ff);
      rad_wdata = radius_new;
      if (state_ff == ST_SWEEP || (state_ff == ST_ROW && off_diag_upd)) begin
         rad_raddr = (state_ff == ST_SWEEP) ? sweep_row_ff[AW-1:0] : to_addr(col_ff);
      end else begin
         rad_raddr = to_addr(req_tdata[IDX_W-1:0]);
      end
      case (state_ff)
         ST_CLEAR: begin
            rad_we    = 1'b1;
            rad_waddr = sweep_row_ff[AW-1:0];
            rad_wdata = '0;
         end
         ST_ROW: begin
            rad_we = off_diag_upd;
         end
         ST_COL: begin
            rad_we    = 1'b1;
            rad_waddr = to_addr(col_ff);
         end
         ST_SWEEP: begin
            rad_we    = sw_clr_ff;
            rad_waddr = sw_row_ff;
            rad_wdata = '0;
         end
         default: begin
            rad_we = 1'b0;
         end
      endcase
   end

   assign cen_we     = (state_ff == ST_ROW) && in_range && is_diag;
   assign fwd_hit_in = rad_we && (rad_waddr == rad_raddr) && (state_ff == ST_COL);

   always_ff @(posedge clock) begin
      if (rad_we) begin
         radius_mem[rad_waddr] <= rad_wdata;
      end
      radius_rd_ff <= radius_mem[rad_raddr];
   end

   always_ff @(posedge clock) begin
      if (cen_we) begin
         centre_mem[to_addr(row_ff)] <= value_ff;
      end
      centre_rd_ff <= centre_mem[sweep_row_ff[AW-1:0]];
   end

   // ---------------- sequencer ----------------
   assign rsp_load = (state_ff == ST_RESULT) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in     = state_ff;
      sweep_row_in = sweep_row_ff;
      sw_in        = '0;
      sw_clr_in    = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            if (sweep_row_ff == LAST_ROW) begin
               state_in     = ST_IDLE;
               sweep_row_in = '0;
            end else begin
               sweep_row_in = sweep_row_ff + ORDER_ONE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_ROW;
            end
         end
         ST_ROW, ST_COL: begin
            if (state_ff == ST_ROW && off_diag_upd) begin
               state_in = ST_COL;
            end else if (last_ff) begin
               state_in = ST_SWEEP;
            end else if (req_accept) begin
               state_in = ST_ROW;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SWEEP: begin
            if (sweep_row_ff != sweep_top) begin
               // rows at or past the order are only zeroed
               sw_in.valid  = (sweep_row_ff < order_ff);
               sw_in.first  = (sweep_row_ff == '0);
               sw_clr_in    = 1'b1;
               sweep_row_in = sweep_row_ff + ORDER_ONE;
            end else if (sw_clr_ff) begin
               state_in     = ST_RESULT;
               sweep_row_in = '0;
            end
         end
         ST_RESULT: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         order_ff     <= ORDER_ONE;
         span_ff      <= '0;
         sweep_row_ff <= '0;
         sw_ff        <= '0;
         sw_clr_ff    <= 1'b0;
         fwd_hit_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         last_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         order_ff     <= order_in;
         span_ff      <= span_in;
         sweep_row_ff <= sweep_row_in;
         sw_ff        <= sw_in;
         sw_clr_ff    <= sw_clr_in;
         fwd_hit_ff   <= fwd_hit_in;
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) begin
            last_ff <= req_tlast;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         row_ff   <= req_tdata[IDX_W-1:0];
         col_ff   <= req_tdata[2*IDX_W-1:IDX_W];
         value_ff <= req_value;
         mag_ff   <= req_value[CENTRE_W-1] ? MAG_W'(-req_value) : MAG_W'(req_value);
      end
      sw_row_ff   <= sweep_row_ff[AW-1:0];
      fwd_data_ff <= rad_wdata;
      if (rsp_load) begin
         rsp_data_ff <= {upper_bound, lower_bound};
      end
   end

   geb_interval u_interval (
      .clock       (clock),
      .reset       (reset),
      .sweep       (sw_ff),
      .centre      (centre_rd_ff),
      .radius      (radius_rd_ff),
      .lower_bound (lower_bound),
      .upper_bound (upper_bound)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ---------------- assertions ----------------
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rad_we && (state_ff == ST_ROW || state_ff == ST_SWEEP) |-> rad_waddr != rad_raddr)
      else $error("radius write and read collide outside the forwarded case");

   a_last_stalls: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_tlast |=> !req_tready)
      else $error("new entry taken right after the final entry");

   a_sweep_range: assert property (@(posedge clock) disable iff (reset)
      sw_ff.valid |-> NW'(sw_row_ff) < order_ff)
      else $error("sweep row beyond matrix order");

   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> !req_tready && !rsp_tvalid)
      else $error("channel active during clearing pass");

endmodule
